>>> rtl/core/tcw_pkg.sv
// tcw_pkg: shared widths, opcodes and character constants of the text console writer.
// No dependencies; used by the interfaces, the submodules and the top level.
package tcw_pkg;

  localparam int OPCODE_W = 2;
  localparam int CHAR_W   = 8;
  localparam int ARG_ROW_W = 5;
  localparam int ARG_COL_W = 7;
  localparam int OUT_ROW_W = 5;
  localparam int OUT_COL_W = 7;
  localparam int OUT_LIN_W = 11;
  localparam int CELL_W   = 16;

  typedef logic [OPCODE_W-1:0] opcode_t;
  typedef logic [CHAR_W-1:0]   byte_t;
  typedef logic [CELL_W-1:0]   cell_t;

  localparam opcode_t OP_PUT    = 2'd0;
  localparam opcode_t OP_CLEAR  = 2'd1;
  localparam opcode_t OP_SETCUR = 2'd2;
  localparam opcode_t OP_READ   = 2'd3;

  localparam byte_t CH_NEWLINE = 8'h0A;
  localparam byte_t CH_RETURN  = 8'h0D;
  localparam byte_t ATTR_RESET = 8'h07;

  // space with light-grey-on-black attribute
  localparam cell_t BLANK_CELL = 16'h0720;
  localparam cell_t ZERO_CELL  = 16'h0000;

endpackage

>>> rtl/core/tcw_cmd_if.sv
// tcw_cmd_if: command channel of the text console writer (valid/ready plus fields).
// Depends on tcw_pkg for field widths.
interface tcw_cmd_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  opcode_t              opcode;
  byte_t                char_code;
  logic [ARG_ROW_W-1:0] row_arg;
  logic [ARG_COL_W-1:0] col_arg;
  logic                 last_of_write;

  modport source (output valid, opcode, char_code, row_arg, col_arg, last_of_write,
                  input ready);
  modport sink   (input valid, opcode, char_code, row_arg, col_arg, last_of_write,
                  output ready);
endinterface

>>> rtl/core/tcw_result_if.sv
// tcw_result_if: result channel of the text console writer (valid/ready plus fields).
// Depends on tcw_pkg for field widths.
interface tcw_result_if import tcw_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OUT_ROW_W-1:0] cursor_row;
  logic [OUT_COL_W-1:0] cursor_col;
  logic [OUT_LIN_W-1:0] cursor_linear;
  byte_t                read_char;
  byte_t                read_attr;
  logic                 illegal;
  logic                 write_done;

  modport source (output valid, cursor_row, cursor_col, cursor_linear, read_char,
                  read_attr, illegal, write_done, input ready);
  modport sink   (input valid, cursor_row, cursor_col, cursor_linear, read_char,
                  read_attr, illegal, write_done, output ready);
endinterface

>>> rtl/core/tcw_addr_unit.sv
// tcw_addr_unit: row/column to linear cell index (row * COLUMNS + col).
// Depends on tcw_pkg only by convention; shared between cursor and read addressing.
module tcw_addr_unit import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int RW = 5,
  parameter int CW = 7,
  parameter int AW = 11
) (
  input  logic [RW-1:0] row,
  input  logic [CW-1:0] col,
  output logic [AW-1:0] lin
);

  localparam logic [AW-1:0] COLS_A = AW'(COLUMNS);

  assign lin = AW'(row) * COLS_A + AW'(col);

endmodule

>>> rtl/core/tcw_cell_ram.sv
// tcw_cell_ram: character/attribute cell buffer, one write and one registered read port.
// Depends on tcw_pkg for the cell type.
module tcw_cell_ram import tcw_pkg::*; #(
  parameter int DEPTH = 2000,
  parameter int AW = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  cell_t         wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output cell_t         rdata
);

  cell_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/text_console_writer.sv
// text_console_writer: text-mode console engine with cell buffer, cursor and sequencer.
// Depends on tcw_pkg, tcw_cmd_if, tcw_result_if, tcw_addr_unit and tcw_cell_ram.
//
// Use: commands enter on cmd (valid/ready), one result per command leaves on result.
// Opcodes: put character, clear screen, set cursor, read cell. The attribute stored with
// printed characters is written through cfg_write/cfg_data; the user must write it only
// while the block is idle, which the block itself does not enforce. One command at a
// time: cmd.ready is high only while the sequencer is idle. A command passes through the
// sequencer states EXEC and EMIT, a legal read also through RDWAIT between them; the
// result is registered as EMIT hands it out. A put that runs past the last row scrolls
// (one cell copied per cycle through the single RAM port pair, a drain state for the
// last copy, then the bottom row blanked). Clear blanks every cell, one cell per cycle.
// After reset a clearing pass zeroes the buffer; no command is taken meanwhile,
// configuration writes are. The result sits in an output register: a stalled receiver
// holds it while the next command is taken and worked on; that command's result then
// waits in the final sequencer state until the register frees.
module text_console_writer import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS = 25
) (
  input  logic          clk,
  input  logic          rst,
  tcw_cmd_if.sink       cmd,
  tcw_result_if.source  result,
  input  logic          cfg_write,
  input  byte_t         cfg_data
);

  localparam int CELLS = ROWS * COLUMNS;
  localparam int RW  = $clog2(ROWS);
  localparam int CW  = $clog2(COLUMNS);
  localparam int RW1 = $clog2(ROWS + 1);
  localparam int CW1 = $clog2(COLUMNS + 1);
  localparam int AW  = $clog2(CELLS);

  localparam logic [AW-1:0] COPY_LAST     = AW'((ROWS - 1) * COLUMNS - 1);
  localparam logic [AW-1:0] LAST_ROW_BASE = AW'((ROWS - 1) * COLUMNS);
  localparam logic [AW-1:0] CELL_LAST     = AW'(CELLS - 1);
  localparam logic [AW-1:0] COLS_A        = AW'(COLUMNS);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_EXEC   = 3'd1;
  localparam logic [2:0] ST_RDWAIT = 3'd2;
  localparam logic [2:0] ST_SCROLL = 3'd3;
  localparam logic [2:0] ST_SDRAIN = 3'd4;
  localparam logic [2:0] ST_BLANK  = 3'd5;
  localparam logic [2:0] ST_EMIT   = 3'd6;

  logic [2:0]     state, state_next;
  logic           init_pass, init_pass_next;
  logic [RW-1:0]  cur_row, cur_row_next;
  logic [CW-1:0]  cur_col, cur_col_next;
  logic [AW-1:0]  ptr, ptr_next;
  logic           cp_valid, cp_valid_next;
  logic [AW-1:0]  cp_addr;
  logic           bad, bad_next;
  byte_t          text_attribute;

  opcode_t              op;
  byte_t                ch;
  logic [ARG_ROW_W-1:0] arg_row;
  logic [ARG_COL_W-1:0] arg_col;
  logic                 last;
  byte_t                rd_char;
  byte_t                rd_attr;

  logic           res_valid;
  logic           emit_fire;
  logic           in_range;
  logic [RW1-1:0] row_inc;
  logic [CW1-1:0] col_inc;

  logic [RW-1:0]  au_row;
  logic [CW-1:0]  au_col;
  logic [AW-1:0]  lin;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  cell_t          ram_wdata;
  logic           ram_re;
  logic [AW-1:0]  ram_raddr;
  cell_t          ram_rdata;

  assign cmd.ready = (state == ST_IDLE);
  assign emit_fire = (state == ST_EMIT) && (!res_valid || result.ready);
  assign in_range  = (32'(arg_row) < 32'(ROWS)) && (32'(arg_col) < 32'(COLUMNS));
  assign row_inc   = RW1'(cur_row) + RW1'(1);
  assign col_inc   = CW1'(cur_col) + CW1'(1);

  // the address unit serves the read address during a read, the cursor otherwise
  always_comb begin
    if (state == ST_EXEC && op == OP_READ) begin
      au_row = RW'(arg_row);
      au_col = CW'(arg_col);
    end else begin
      au_row = cur_row;
      au_col = cur_col;
    end
  end

  tcw_addr_unit #(
    .COLUMNS (COLUMNS),
    .RW      (RW),
    .CW      (CW),
    .AW      (AW)
  ) u_addr (
    .row (au_row),
    .col (au_col),
    .lin (lin)
  );

  tcw_cell_ram #(
    .DEPTH (CELLS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    logic row_adv;
    state_next     = state;
    init_pass_next = init_pass;
    cur_row_next   = cur_row;
    cur_col_next   = cur_col;
    ptr_next       = ptr;
    bad_next       = bad;
    cp_valid_next  = 1'b0;
    row_adv        = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = lin;
    ram_wdata      = {text_attribute, ch};
    ram_re         = 1'b0;
    ram_raddr      = lin;
    case (state)
      ST_IDLE: begin
        if (cmd.valid) begin
          bad_next   = 1'b0;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op)
          OP_PUT: begin
            if (ch == CH_NEWLINE) begin
              cur_col_next = '0;
              row_adv      = 1'b1;
            end else if (ch == CH_RETURN) begin
              cur_col_next = '0;
            end else begin
              ram_we = 1'b1;
              if (col_inc == CW1'(COLUMNS)) begin
                cur_col_next = '0;
                row_adv      = 1'b1;
              end else begin
                cur_col_next = CW'(col_inc);
              end
            end
            state_next = ST_EMIT;
            if (row_adv) begin
              if (row_inc == RW1'(ROWS)) begin
                cur_row_next = RW'(ROWS - 1);
                ptr_next     = '0;
                state_next   = ST_SCROLL;
              end else begin
                cur_row_next = RW'(row_inc);
              end
            end
          end
          OP_CLEAR: begin
            cur_row_next = '0;
            cur_col_next = '0;
            ptr_next     = '0;
            state_next   = ST_BLANK;
          end
          OP_SETCUR: begin
            if (in_range) begin
              cur_row_next = RW'(arg_row);
              cur_col_next = CW'(arg_col);
            end else begin
              bad_next = 1'b1;
            end
            state_next = ST_EMIT;
          end
          default: begin
            if (in_range) begin
              ram_re     = 1'b1;
              state_next = ST_RDWAIT;
            end else begin
              bad_next   = 1'b1;
              state_next = ST_EMIT;
            end
          end
        endcase
      end
      ST_RDWAIT: begin
        state_next = ST_EMIT;
      end
      ST_SCROLL: begin
        // read one row ahead, write the cell read in the previous cycle
        ram_re        = 1'b1;
        ram_raddr     = ptr + COLS_A;
        cp_valid_next = 1'b1;
        ram_we        = cp_valid;
        ram_waddr     = cp_addr;
        ram_wdata     = ram_rdata;
        if (ptr == COPY_LAST) begin
          state_next = ST_SDRAIN;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      ST_SDRAIN: begin
        ram_we     = 1'b1;
        ram_waddr  = cp_addr;
        ram_wdata  = ram_rdata;
        ptr_next   = LAST_ROW_BASE;
        state_next = ST_BLANK;
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_waddr = ptr;
        ram_wdata = init_pass ? ZERO_CELL : BLANK_CELL;
        if (ptr == CELL_LAST) begin
          ptr_next       = '0;
          init_pass_next = 1'b0;
          state_next     = init_pass ? ST_IDLE : ST_EMIT;
        end else begin
          ptr_next = ptr + AW'(1);
        end
      end
      ST_EMIT: begin
        if (emit_fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_BLANK;
      init_pass      <= 1'b1;
      cur_row        <= '0;
      cur_col        <= '0;
      ptr            <= '0;
      cp_valid       <= 1'b0;
      bad            <= 1'b0;
      res_valid      <= 1'b0;
      text_attribute <= ATTR_RESET;
    end else begin
      state     <= state_next;
      init_pass <= init_pass_next;
      cur_row   <= cur_row_next;
      cur_col   <= cur_col_next;
      ptr       <= ptr_next;
      cp_valid  <= cp_valid_next;
      bad       <= bad_next;
      if (emit_fire) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg_write) begin
        text_attribute <= cfg_data;
      end
    end
  end

  // request fields, read data and result payload
  always_ff @(posedge clk) begin
    cp_addr <= ptr;
    if (cmd.valid && cmd.ready) begin
      op      <= cmd.opcode;
      ch      <= cmd.char_code;
      arg_row <= cmd.row_arg;
      arg_col <= cmd.col_arg;
      last    <= cmd.last_of_write;
    end
    if (state == ST_EXEC) begin
      rd_char <= '0;
      rd_attr <= '0;
    end else if (state == ST_RDWAIT) begin
      rd_char <= ram_rdata[CHAR_W-1:0];
      rd_attr <= ram_rdata[CELL_W-1:CHAR_W];
    end
    if (emit_fire) begin
      result.cursor_row    <= OUT_ROW_W'(cur_row);
      result.cursor_col    <= OUT_COL_W'(cur_col);
      result.cursor_linear <= OUT_LIN_W'(lin);
      result.read_char     <= rd_char;
      result.read_attr     <= rd_attr;
      result.illegal       <= bad;
      result.write_done    <= (op == OP_PUT) && last;
    end
  end

  assign result.valid = res_valid;

endmodule

>>> rtl/core/tcw_checker.sv
// tcw_checker: port-level checks on the text console writer, bound to the top level.
// Depends on text_console_writer and its channel interfaces (through the bind below).
module tcw_checker import tcw_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 cmd_valid,
  input logic                 cmd_ready,
  input logic                 res_valid,
  input logic                 res_ready,
  input logic [OUT_LIN_W-1:0] res_cursor_linear,
  input byte_t                res_read_char,
  input byte_t                res_read_attr,
  input logic                 res_illegal,
  input logic                 res_write_done
);

  // buffer clearing pass follows reset: no request taken just after it
  a_no_req_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !cmd_ready)
    else $error("command taken during post-reset clearing pass");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("ready stayed high after a request was taken");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_cursor_linear)
      && $stable(res_read_char) && $stable(res_read_attr) && $stable(res_illegal))
    else $error("stalled result changed or dropped");

  a_illegal_no_data: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_illegal |-> res_read_char == 8'h00 && res_read_attr == 8'h00
      && !res_write_done)
    else $error("illegal result carries cell data or write completion");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .res_valid         (result.valid),
  .res_ready         (result.ready),
  .res_cursor_linear (result.cursor_linear),
  .res_read_char     (result.read_char),
  .res_read_attr     (result.read_attr),
  .res_illegal       (result.illegal),
  .res_write_done    (result.write_done)
);
